// ----- design/top_k_ranking_list_unit_macros.svh -----
// Assertion macros shared by the ranking list checker.
`ifndef TOP_K_RANKING_LIST_UNIT_MACROS_SVH
`define TOP_K_RANKING_LIST_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TKRL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TKRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tkrl_pkg.sv -----
// Types and constants shared by the ranking list unit.
`default_nettype none

package tkrl_pkg;

    localparam int KEY_W              = 32;
    localparam int SCORE_W            = 32;
    localparam int SLOT_FIELD_W       = 2;
    localparam int RANK_FIELD_W       = 4;
    localparam int DEF_LIST_DEPTH     = 10;
    localparam int DEF_ACTIVITY_SLOTS = 4;
    localparam int S_TDATA_W          = 72;
    localparam int M_TDATA_W          = 72;
    localparam int S_TUSER_W          = 1;
    localparam int M_TUSER_W          = 1;
    localparam int M_FIELDS_W         = SLOT_FIELD_W + RANK_FIELD_W + KEY_W + SCORE_W;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } entry_t;

    // Command from the controller to every cell of the row.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // Compare results a cell shows to its neighbours.
    typedef struct packed {
        logic match;
        logic ge;
        logic lt;
    } cell_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- design/top_k_ranking_list_unit.sv -----
// A transaction is taken in the idle state, the list is rebuilt in the update state, and the
// first result shows in the emit state; results then leave one per cycle while m_tready is
// high, rank 0 first. An item gives n results (n up to LIST_DEPTH, 1 for a clear, 0 for a
// dropped update), shifted out through the cell row; no new item is taken until the last leaves.
// Reset clears every slot's list length at once; stored entries need no clearing pass.
`default_nettype none

module top_k_ranking_list_unit
    import tkrl_pkg::*;
#(
    parameter int LIST_DEPTH     = DEF_LIST_DEPTH,
    parameter int ACTIVITY_SLOTS = DEF_ACTIVITY_SLOTS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // activity_slot, resource_key, score_value
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // out_slot, rank, out_key, out_score
    output logic [M_TUSER_W-1:0]      m_tuser,  // entry_valid
    output logic                      m_tlast
);

    localparam int SLOT_W = (ACTIVITY_SLOTS > 1) ? $clog2(ACTIVITY_SLOTS) : 1;
    localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
    localparam int RANK_W = $clog2(LIST_DEPTH);

    state_t state_reg, state_next;

    logic                    kind_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic [SLOT_W-1:0]       slot_idx_reg;
    entry_t                  item_reg;

    logic [LEN_W-1:0]  len_reg [ACTIVITY_SLOTS];
    logic [LEN_W-1:0]  emit_len_reg, emit_len_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              clear_reg, clear_next;

    logic             len_we;
    logic [LEN_W-1:0] len_wdata;
    cell_ctrl_t       cell_ctrl;

    entry_t      cur_w   [LIST_DEPTH];
    entry_t      sh_w    [LIST_DEPTH];
    cell_flags_t flags_w [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] valid_w;
    logic [LIST_DEPTH-1:0] match_w;
    logic [LIST_DEPTH-1:0] mb_w;

    logic [4:0]         slot_wide;
    logic               in_range;
    logic               in_take;
    logic               out_take;
    logic               is_last;
    logic [LEN_W-1:0]   len_cur;
    logic               full;
    logic               any_match;
    logic [SCORE_W-1:0] threshold;
    logic               drop;
    logic [LEN_W-1:0]   new_len;

    assign slot_wide = {3'b000, s_tdata[SLOT_FIELD_W-1:0]};
    assign in_range  = slot_wide < 5'(ACTIVITY_SLOTS);
    assign in_take   = s_tvalid && s_tready;
    assign out_take  = m_tvalid && m_tready;

    assign len_cur   = len_reg[slot_idx_reg];
    assign full      = len_cur == LEN_W'(LIST_DEPTH);
    assign any_match = |match_w;
    assign threshold = full ? cur_w[LIST_DEPTH-1].score : '0;
    assign drop      = item_reg.score <= threshold;
    assign new_len   = (any_match || full) ? len_cur : len_cur + LEN_W'(1);
    assign is_last   = clear_reg || ((LEN_W'(rank_reg) + LEN_W'(1)) == emit_len_reg);

    // Cell row
    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            entry_t      left_entry, right_entry, right_sh;
            cell_flags_t left_flags, right_flags;
            logic        mb_left;

            assign valid_w[g] = LEN_W'(g) < len_cur;
            assign match_w[g] = flags_w[g].match;
            // match found at this rank or above
            assign mb_w[g]    = |match_w[g:0];

            if (g == 0) begin : g_first
                assign left_entry = '0;
                assign left_flags = '{match: 1'b0, ge: 1'b1, lt: 1'b1};
                assign mb_left    = 1'b0;
            end else begin : g_inner
                assign left_entry = cur_w[g-1];
                assign left_flags = flags_w[g-1];
                assign mb_left    = mb_w[g-1];
            end

            if (g == LIST_DEPTH - 1) begin : g_tail
                assign right_entry = '0;
                assign right_flags = '0;
                assign right_sh    = '0;
            end else begin : g_body
                assign right_entry = cur_w[g+1];
                assign right_flags = flags_w[g+1];
                assign right_sh    = sh_w[g+1];
            end

            tkrl_cell #(
                .SLOTS  (ACTIVITY_SLOTS),
                .SLOT_W (SLOT_W)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (cell_ctrl),
                .slot_idx    (slot_idx_reg),
                .new_entry   (item_reg),
                .valid       (valid_w[g]),
                .mb_self     (mb_w[g]),
                .mb_left     (mb_left),
                .left_entry  (left_entry),
                .left_flags  (left_flags),
                .right_entry (right_entry),
                .right_flags (right_flags),
                .right_sh    (right_sh),
                .cur         (cur_w[g]),
                .flags       (flags_w[g]),
                .sh          (sh_w[g])
            );
        end
    endgenerate

    // Controller
    always_comb begin
        state_next    = state_reg;
        rank_next     = rank_reg;
        emit_len_next = emit_len_reg;
        clear_next    = clear_reg;
        len_we        = 1'b0;
        len_wdata     = '0;
        cell_ctrl     = '0;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_take && in_range) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                rank_next = '0;
                if (kind_reg == KIND_CLEAR) begin
                    len_we        = 1'b1;
                    len_wdata     = '0;
                    emit_len_next = LEN_W'(1);
                    clear_next    = 1'b1;
                    state_next    = ST_EMIT;
                end else if (drop) begin
                    state_next = ST_IDLE;
                end else begin
                    cell_ctrl.load = 1'b1;
                    len_we         = 1'b1;
                    len_wdata      = new_len;
                    emit_len_next  = new_len;
                    clear_next     = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (out_take) begin
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        rank_next       = rank_reg + RANK_W'(1);
                        cell_ctrl.shift = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rank_reg     <= '0;
            emit_len_reg <= '0;
            clear_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rank_reg     <= rank_next;
            emit_len_reg <= emit_len_next;
            clear_reg    <= clear_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ACTIVITY_SLOTS; i++) begin
                len_reg[i] <= '0;
            end
        end else if (len_we) begin
            len_reg[slot_idx_reg] <= len_wdata;
        end
    end

    // Hold the accepted transaction for the update cycle and the emission
    always_ff @(posedge aclk) begin
        if (in_take) begin
            kind_reg       <= s_tuser[0];
            slot_reg       <= s_tdata[SLOT_FIELD_W-1:0];
            slot_idx_reg   <= SLOT_W'(slot_wide);
            item_reg.key   <= s_tdata[SLOT_FIELD_W +: KEY_W];
            item_reg.score <= s_tdata[SLOT_FIELD_W + KEY_W +: SCORE_W];
        end
    end

    // Cell 0's shift stage is the output register
    always_comb begin
        m_tdata = {
            (M_TDATA_W - M_FIELDS_W)'(0),
            clear_reg ? {SCORE_W{1'b0}} : sh_w[0].score,
            clear_reg ? {KEY_W{1'b0}}   : sh_w[0].key,
            RANK_FIELD_W'(rank_reg),
            slot_reg
        };
        m_tuser = M_TUSER_W'(!clear_reg);
        m_tlast = is_last;
    end

endmodule

`default_nettype wire

// ----- design/tkrl_cell.sv -----
// One rank position of the list: stored entries for every slot plus a shift-out stage.
`default_nettype none

module tkrl_cell
    import tkrl_pkg::*;
#(
    parameter int SLOTS  = DEF_ACTIVITY_SLOTS,
    parameter int SLOT_W = 2
) (
    input  wire logic              aclk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [SLOT_W-1:0] slot_idx,
    input  wire entry_t            new_entry,
    input  wire logic              valid,
    input  wire logic              mb_self,
    input  wire logic              mb_left,
    input  wire entry_t            left_entry,
    input  wire cell_flags_t       left_flags,
    input  wire entry_t            right_entry,
    input  wire cell_flags_t       right_flags,
    input  wire entry_t            right_sh,
    output entry_t                 cur,
    output cell_flags_t            flags,
    output entry_t                 sh
);

    entry_t entries_reg [SLOTS];
    entry_t sh_reg;
    entry_t entry_next;

    assign cur = entries_reg[slot_idx];
    assign sh  = sh_reg;

    always_comb begin
        flags.match = valid && (cur.key == new_entry.key);
        flags.ge    = valid && (cur.score >= new_entry.score);
        // compacted list entry at this rank still outranks the new score
        flags.lt    = mb_self ? right_flags.ge : flags.ge;
    end

    always_comb begin
        if (flags.lt) begin
            entry_next = mb_self ? right_entry : cur;
        end else if (left_flags.lt) begin
            entry_next = new_entry;
        end else begin
            entry_next = mb_left ? cur : left_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            entries_reg[slot_idx] <= entry_next;
            sh_reg                <= entry_next;
        end else if (ctrl.shift) begin
            sh_reg <= right_sh;
        end
    end

endmodule

`default_nettype wire

// ----- design/tkrl_checker.sv -----
// Port-level checker for the ranking list unit, bound to the top level.
`default_nettype none

`include "top_k_ranking_list_unit_macros.svh"

module tkrl_checker
    import tkrl_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser,
    input wire logic                 m_tlast
);

    `TKRL_ASSERT_IMPL(a_one_side_busy, aclk, aresetn, m_tvalid, !s_tready, "input taken during emission")
    `TKRL_ASSERT_NEXT(a_list_continues, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid, "list cut short")
    `TKRL_ASSERT_NEXT(a_rank_steps, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tdata[5:2] == $past(m_tdata[5:2]) + 4'd1, "rank not consecutive")
    `TKRL_ASSERT_IMPL(a_empty_is_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast && (m_tdata[5:2] == 4'd0), "empty list result not single")

endmodule

bind top_k_ranking_list_unit tkrl_checker u_tkrl_checker (.*);

`default_nettype wire

// ----- tb/top_k_ranking_list_unit_tb.sv -----
// Self-checking testbench for the top-k ranking list unit.
`default_nettype none

module top_k_ranking_list_unit_tb
    import tkrl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = DEF_LIST_DEPTH;
    localparam int SLOTS   = DEF_ACTIVITY_SLOTS;
    localparam int S_PAD_W = S_TDATA_W - SLOT_FIELD_W - KEY_W - SCORE_W;
    localparam int RANK_LO = SLOT_FIELD_W;
    localparam int KEY_LO  = RANK_LO + RANK_FIELD_W;
    localparam int SCORE_LO = KEY_LO + KEY_W;
    localparam int KEY_POOL = 24;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic [RANK_FIELD_W-1:0] rank;
        logic [KEY_W-1:0]        key;
        logic [SCORE_W-1:0]      score;
        logic                    valid;
        logic                    last;
    } ranked_entry_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // Mirror of the unit's ranking lists
    logic [KEY_W-1:0]   mirror_keys[SLOTS][DEPTH];
    logic [SCORE_W-1:0] mirror_scores[SLOTS][DEPTH];
    int                 mirror_len[SLOTS];

    ranked_entry_t      expected_entries[$];
    logic [KEY_W-1:0]   key_pool[KEY_POOL];
    int                 mismatch_count = 0;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;

    top_k_ranking_list_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [SCORE_W-1:0] slot_threshold(int slot);
        return (mirror_len[slot] >= DEPTH) ? mirror_scores[slot][DEPTH-1] : '0;
    endfunction

    // Apply one accepted transaction to the mirror and queue the list it emits.
    function automatic void rank_update(logic kind, logic [SLOT_FIELD_W-1:0] slot,
                                        logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score);
        int            len;
        int            pos;
        int            newlen;
        ranked_entry_t entry;
        len = mirror_len[slot];
        if (kind == KIND_CLEAR) begin
            mirror_len[slot] = 0;
            entry = '{slot: slot, rank: '0, key: '0, score: '0, valid: 1'b0, last: 1'b1};
            expected_entries.push_back(entry);
            return;
        end
        if (score <= slot_threshold(slot))
            return;
        // drop any older entry for the same resource
        for (int i = 0; i < len; i++) begin
            if (mirror_keys[slot][i] == key) begin
                for (int j = i; j + 1 < len; j++) begin
                    mirror_keys[slot][j]   = mirror_keys[slot][j+1];
                    mirror_scores[slot][j] = mirror_scores[slot][j+1];
                end
                len--;
                break;
            end
        end
        // ties keep the older entry ahead
        pos = len;
        for (int i = 0; i < len; i++) begin
            if (mirror_scores[slot][i] < score) begin
                pos = i;
                break;
            end
        end
        newlen = (len < DEPTH) ? len + 1 : DEPTH;
        if (pos < DEPTH) begin
            for (int j = newlen - 1; j > pos; j--) begin
                mirror_keys[slot][j]   = mirror_keys[slot][j-1];
                mirror_scores[slot][j] = mirror_scores[slot][j-1];
            end
            mirror_keys[slot][pos]   = key;
            mirror_scores[slot][pos] = score;
        end
        mirror_len[slot] = newlen;
        for (int i = 0; i < newlen; i++) begin
            entry = '{slot: slot, rank: RANK_FIELD_W'(i), key: mirror_keys[slot][i],
                      score: mirror_scores[slot][i], valid: 1'b1, last: (i + 1 == newlen)};
            expected_entries.push_back(entry);
        end
    endfunction

    // Present one transaction and hold it until the unit takes it.
    task automatic send_item(logic kind, logic [SLOT_FIELD_W-1:0] slot,
                             logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{S_PAD_W{1'b0}}, score, key, slot};
        do @(posedge aclk); while (!s_tready);
        rank_update(kind, slot, key, score);
    endtask

    // Hold off until every queued result has left, then let a dropped update settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_entries.size() != 0)
            @(posedge aclk);
        repeat (DEPTH + 4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        ranked_entry_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_entries.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%b tlast=%b",
                       m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                want = expected_entries.pop_front();
                if (m_tdata[SLOT_FIELD_W-1:0] !== want.slot) begin
                    $error("out_slot: expected %0d, got %0d", want.slot,
                           m_tdata[SLOT_FIELD_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[RANK_LO +: RANK_FIELD_W] !== want.rank) begin
                    $error("rank: expected %0d, got %0d", want.rank,
                           m_tdata[RANK_LO +: RANK_FIELD_W]);
                    mismatch_count++;
                end
                if (m_tdata[KEY_LO +: KEY_W] !== want.key) begin
                    $error("out_key: expected %h, got %h", want.key, m_tdata[KEY_LO +: KEY_W]);
                    mismatch_count++;
                end
                if (m_tdata[SCORE_LO +: SCORE_W] !== want.score) begin
                    $error("out_score: expected %h, got %h", want.score,
                           m_tdata[SCORE_LO +: SCORE_W]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.valid) begin
                    $error("entry_valid: expected %b, got %b", want.valid, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Extreme keys and scores, zero score dropped, clear of an empty list.
    task automatic test_extremes();
        send_item(KIND_CLEAR, 2'd0, '0, '0);
        send_item(KIND_UPDATE, 2'd0, '0, '0);
        send_item(KIND_UPDATE, 2'd3, '1, '1);
        send_item(KIND_UPDATE, 2'd3, '0, 32'd1);
        send_item(KIND_UPDATE, 2'd3, '0, 32'h8000_0000);
        send_item(KIND_CLEAR, 2'd3, '1, '1);
    endtask

    // Equal scores: a newcomer lands behind entries of the same score.
    task automatic test_ties();
        send_item(KIND_UPDATE, 2'd1, 32'd10, 32'h0001_0000);
        send_item(KIND_UPDATE, 2'd1, 32'd11, 32'h0001_0000);
        send_item(KIND_UPDATE, 2'd1, 32'd12, 32'h0002_0000);
        send_item(KIND_UPDATE, 2'd1, 32'd10, 32'h0001_0000);
    endtask

    // Fill a list, then probe the threshold, eviction and a re-scored entry.
    task automatic test_full_list();
        for (int i = 0; i < DEPTH; i++)
            send_item(KIND_UPDATE, 2'd2, 32'd20 + i, (i + 1) << 16);
        send_item(KIND_UPDATE, 2'd2, 32'd40, 32'h0001_0000);
        send_item(KIND_UPDATE, 2'd2, 32'd40, 32'h0001_0001);
        send_item(KIND_UPDATE, 2'd2, 32'd25, 32'h00FF_0000);
    endtask

    task automatic test_random_phase(int count, int idle_pct, int stall_pct);
        logic                    kind;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [KEY_W-1:0]        key;
        logic [SCORE_W-1:0]      score;
        int                      pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
            kind = ($urandom_range(0, 99) < 4) ? KIND_CLEAR : KIND_UPDATE;
            key  = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                                : $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                score = $urandom;
            else if (pick < 70)
                score = $urandom_range(0, 8) << 16;
            else
                score = slot_threshold(slot) + $urandom_range(0, 2);
            send_item(kind, slot, key, score);
        end
        wait_drained();
    endtask

    initial begin
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        foreach (mirror_len[i])
            mirror_len[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_ties();
        test_full_list();
        wait_drained();
        test_random_phase(90, 0, 0);
        test_random_phase(95, 55, 0);
        test_random_phase(95, 0, 55);
        test_random_phase(95, 26, 26);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
